@@ design/lobm_pkg.sv @@
// Shared types and constants for the limit order book matcher.
// No dependencies.
package lobm_pkg;
  localparam int unsigned PriceLevelsDef = 256;
  localparam int unsigned QueueDepthDef  = 16;
  localparam int unsigned PriceW  = 8;
  localparam int unsigned VolW    = 16;
  localparam int unsigned TradeW  = 21;
  localparam int unsigned FillW   = 6;

  typedef struct packed {
    logic              is_bid;
    logic [PriceW-1:0] order_price;
    logic [VolW-1:0]   order_volume;
  } order_t;

  typedef struct packed {
    logic              status;
    logic [TradeW-1:0] traded_volume;
    logic [FillW-1:0]  fill_count;
    logic [PriceW-1:0] best_bid;
    logic              bid_valid;
    logic [PriceW-1:0] best_ask;
    logic              ask_valid;
  } result_t;
endpackage

@@ design/lobm_if.sv @@
// Valid/ready channel interfaces for orders and results.
// Depends on lobm_pkg.
interface lobm_order_if import lobm_pkg::*; ();
  logic   valid;
  logic   ready;
  order_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface lobm_result_if import lobm_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

@@ design/lobm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lobm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/lobm_front.sv @@
// Front end: accepts orders and holds them in a two-entry queue for the engine.
// Depends on lobm_pkg and lobm_if.
module lobm_front import lobm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  lobm_order_if.sink in_i,
  output logic   q_valid_o,
  output order_t q_word_o,
  input  logic   q_pop_i
);
  order_t     buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_word_o   = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_i.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> cnt_q == 2'd2)
    else $error("queue lost an entry");
endmodule

@@ design/lobm_engine.sv @@
// Back end: inserts an order, runs one match round, finds best prices.
// Depends on lobm_pkg, lobm_if and lobm_ram.
module lobm_engine import lobm_pkg::*; #(
  parameter int unsigned PriceLevels = PriceLevelsDef,
  parameter int unsigned QueueDepth  = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  order_t q_word_i,
  output logic   q_pop_o,
  lobm_result_if.source out_o
);
  localparam int unsigned LvlW  = (PriceLevels > 1) ? $clog2(PriceLevels) : 1;
  localparam int unsigned SlotW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW = $clog2(PriceLevels * QueueDepth);
  localparam int unsigned PtrW  = SlotW + CntW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StIns   = 4'd1;
  localparam logic [3:0] StScan  = 4'd2;
  localparam logic [3:0] StCheck = 4'd3;
  localparam logic [3:0] StRd    = 4'd4;
  localparam logic [3:0] StPtr   = 4'd5;
  localparam logic [3:0] StWait  = 4'd6;
  localparam logic [3:0] StPair  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0] st_q;
  logic [PriceLevels-1:0] bmap_q, amap_q;
  logic [SlotW-1:0] bhd_q, ahd_q;
  logic [CntW-1:0]  bct_q, act_q;
  logic [LvlW-1:0]  scan_q, bb_q, ba_q;
  logic             bfound_q, afound_q, match_q;
  logic [TradeW-1:0] trade_q;
  logic [FillW-1:0]  fill_q;
  logic              status_q;
  logic [VolW-1:0]   bv_q, av_q;
  logic              bload_q, aload_q;
  logic              ovalid_q;
  result_t           res_q;

  // queue storage
  logic             bwe, awe;
  logic [AddrW-1:0] bwa, awa, bra, ara;
  logic [VolW-1:0]  bwd, awd, brd, ard;

  // level pointers {head, count}; valid only where the occupancy bit is set
  logic             bpwe, apwe;
  logic [LvlW-1:0]  bpwa, apwa, bpra, apra;
  logic [PtrW-1:0]  bpwd, apwd, bprd, aprd;

  lobm_ram #(.Width(VolW), .Depth(PriceLevels * QueueDepth)) u_bid_ram (
    .clk_i, .we_i(bwe), .waddr_i(bwa), .wdata_i(bwd), .raddr_i(bra), .rdata_o(brd));
  lobm_ram #(.Width(VolW), .Depth(PriceLevels * QueueDepth)) u_ask_ram (
    .clk_i, .we_i(awe), .waddr_i(awa), .wdata_i(awd), .raddr_i(ara), .rdata_o(ard));
  lobm_ram #(.Width(PtrW), .Depth(PriceLevels)) u_bid_ptr (
    .clk_i, .we_i(bpwe), .waddr_i(bpwa), .wdata_i(bpwd), .raddr_i(bpra), .rdata_o(bprd));
  lobm_ram #(.Width(PtrW), .Depth(PriceLevels)) u_ask_ptr (
    .clk_i, .we_i(apwe), .waddr_i(apwa), .wdata_i(apwd), .raddr_i(apra), .rdata_o(aprd));

  function automatic logic [AddrW-1:0] slot(input logic [LvlW-1:0] l,
                                            input logic [SlotW-1:0] s);
    logic [AddrW+SlotW:0] a;
    a = AddrW'(l) * AddrW'(QueueDepth) + (AddrW+SlotW+1)'(s);
    return a[AddrW-1:0];
  endfunction

  function automatic logic [SlotW-1:0] wrap(input logic [SlotW:0] v);
    logic [SlotW:0] r;
    r = (v >= (SlotW+1)'(QueueDepth)) ? v - (SlotW+1)'(QueueDepth) : v;
    return (QueueDepth > 1) ? r[SlotW-1:0] : '0;
  endfunction

  logic [LvlW-1:0] plvl;
  logic            prange, pfull;
  logic [PtrW-1:0] pptr;
  logic [CntW-1:0] pcnt;
  logic [SlotW-1:0] phead, ptail;
  assign prange = ({{(32-PriceW){1'b0}}, q_word_i.order_price} < PriceLevels);
  assign plvl   = LvlW'(q_word_i.order_price);
  // an empty level reads as head 0, count 0
  assign pptr   = q_word_i.is_bid ? (bmap_q[plvl] ? bprd : '0)
                                  : (amap_q[plvl] ? aprd : '0);
  assign pcnt   = pptr[CntW-1:0];
  assign phead  = pptr[PtrW-1:CntW];
  assign pfull  = !prange || (pcnt == CntW'(QueueDepth));
  assign ptail  = wrap({1'b0, phead} + (SlotW+1)'(pcnt));

  logic [VolW-1:0] bcur, acur, mvol, bnew, anew;
  assign bcur = bload_q ? brd : bv_q;
  assign acur = aload_q ? ard : av_q;
  assign mvol = (bcur < acur) ? bcur : acur;
  assign bnew = bcur - mvol;
  assign anew = acur - mvol;
  logic [CntW-1:0]  bc_nx, ac_nx;
  logic [SlotW-1:0] bh_nx, ah_nx;
  assign bc_nx = bct_q - CntW'(bnew == '0);
  assign ac_nx = act_q - CntW'(anew == '0);
  assign bh_nx = (bnew == '0) ? wrap({1'b0, bhd_q} + (SlotW+1)'(1)) : bhd_q;
  assign ah_nx = (anew == '0) ? wrap({1'b0, ahd_q} + (SlotW+1)'(1)) : ahd_q;

  assign bpra = (st_q == StRd) ? bb_q : plvl;
  assign apra = (st_q == StRd) ? ba_q : plvl;

  always_comb begin
    bwe = 1'b0; awe = 1'b0;
    bwa = slot(plvl, ptail); awa = slot(plvl, ptail);
    bwd = q_word_i.order_volume; awd = q_word_i.order_volume;
    bra = slot(bb_q, bhd_q);
    ara = slot(ba_q, ahd_q);
    bpwe = 1'b0; apwe = 1'b0;
    bpwa = plvl; apwa = plvl;
    bpwd = {phead, pcnt + CntW'(1)};
    apwd = {phead, pcnt + CntW'(1)};
    if (st_q == StIns && !pfull) begin
      bwe  = q_word_i.is_bid;
      awe  = !q_word_i.is_bid;
      bpwe = q_word_i.is_bid;
      apwe = !q_word_i.is_bid;
    end else if (st_q == StPair) begin
      bwe = 1'b1; awe = 1'b1;
      bwa = slot(bb_q, bhd_q); bwd = bnew;
      awa = slot(ba_q, ahd_q); awd = anew;
      bpwe = 1'b1; apwe = 1'b1;
      bpwa = bb_q; bpwd = {bh_nx, bc_nx};
      apwa = ba_q; apwd = {ah_nx, ac_nx};
    end
  end

  assign q_pop_o     = (st_q == StIns);
  assign out_o.valid = ovalid_q;
  assign out_o.word  = res_q;

  always_ff @(posedge clk_i) begin
    if (st_q == StPair) begin
      bv_q <= bnew;
      av_q <= anew;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      bmap_q <= '0; amap_q <= '0;
      bhd_q <= '0; ahd_q <= '0;
      bct_q <= '0; act_q <= '0;
      scan_q <= '0; bb_q <= '0; ba_q <= '0;
      bfound_q <= 1'b0; afound_q <= 1'b0; match_q <= 1'b0;
      trade_q <= '0; fill_q <= '0; status_q <= 1'b0;
      bload_q <= 1'b0; aload_q <= 1'b0;
      ovalid_q <= 1'b0; res_q <= '0;
    end else begin
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      case (st_q)
        // the pointer read of the order's level lands at this edge
        StIdle: begin
          if (q_valid_i && !ovalid_q) st_q <= StIns;
        end
        StIns: begin
          status_q <= pfull;
          trade_q  <= '0;
          fill_q   <= '0;
          match_q  <= !pfull;
          if (!pfull) begin
            if (q_word_i.is_bid) bmap_q[plvl] <= 1'b1;
            else amap_q[plvl] <= 1'b1;
          end
          scan_q <= '0; bfound_q <= 1'b0; afound_q <= 1'b0;
          bb_q <= '0; ba_q <= '0;
          st_q <= StScan;
        end
        // walk levels once: lowest ask stops updating, highest bid keeps updating
        StScan: begin
          if (bmap_q[scan_q]) begin
            bb_q <= scan_q; bfound_q <= 1'b1;
          end
          if (amap_q[scan_q] && !afound_q) begin
            ba_q <= scan_q; afound_q <= 1'b1;
          end
          if (scan_q == LvlW'(PriceLevels - 1)) st_q <= StCheck;
          else scan_q <= scan_q + LvlW'(1);
        end
        StCheck: begin
          if (match_q && bfound_q && afound_q && bb_q >= ba_q) begin
            match_q <= 1'b0;
            st_q <= StRd;
          end else begin
            st_q <= StOut;
          end
        end
        StRd: st_q <= StPtr;
        StPtr: begin
          bhd_q <= bprd[PtrW-1:CntW]; bct_q <= bprd[CntW-1:0];
          ahd_q <= aprd[PtrW-1:CntW]; act_q <= aprd[CntW-1:0];
          bload_q <= 1'b1; aload_q <= 1'b1;
          st_q <= StWait;
        end
        StWait: st_q <= StPair;
        StPair: begin
          trade_q <= trade_q + TradeW'(mvol);
          fill_q  <= fill_q + FillW'(1);
          bct_q <= bc_nx;
          act_q <= ac_nx;
          bhd_q <= bh_nx;
          ahd_q <= ah_nx;
          bload_q <= (bnew == '0);
          aload_q <= (anew == '0);
          if (bc_nx == '0 || ac_nx == '0) begin
            if (bc_nx == '0) bmap_q[bb_q] <= 1'b0;
            if (ac_nx == '0) amap_q[ba_q] <= 1'b0;
            scan_q <= '0; bfound_q <= 1'b0; afound_q <= 1'b0;
            bb_q <= '0; ba_q <= '0;
            st_q <= StScan;
          end else begin
            // new head needs a RAM read
            st_q <= StWait;
          end
        end
        StOut: begin
          res_q.status        <= status_q;
          res_q.traded_volume <= trade_q;
          res_q.fill_count    <= fill_q;
          res_q.best_bid      <= PriceW'(bb_q);
          res_q.bid_valid     <= bfound_q;
          res_q.best_ask      <= PriceW'(ba_q);
          res_q.ask_valid     <= afound_q;
          ovalid_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StPair |-> (bct_q != '0 && act_q != '0))
    else $error("pairing with an empty level");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StPtr |-> (bmap_q[bb_q] && amap_q[ba_q]))
    else $error("matching an unoccupied level");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_o.ready) |=> (ovalid_q && $stable(res_q)))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StOut |-> !ovalid_q)
    else $error("result overwritten");
endmodule

@@ design/limit_order_book_matcher.sv @@
// Top level of the limit order book matcher.
// Depends on lobm_pkg, lobm_if, lobm_front and lobm_engine.
//
// Orders enter through a two-entry queue; the engine takes one at a time
// and starts the next only after the previous result word is taken. An
// order passes a level lookup, an insert, a scan of all PRICE_LEVELS
// levels over the occupancy maps and a check; when the book crosses,
// the two level pointers are fetched, each head pairing is a RAM read
// then an update, and once a level empties a second scan and check
// follow; then the result word is registered for output. The level
// memories need no clearing after reset: a clear occupancy bit marks
// its level as empty whatever the pointer and slot memories hold.
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int unsigned PRICE_LEVELS      = PriceLevelsDef,
  parameter int unsigned LEVEL_QUEUE_DEPTH = QueueDepthDef
) (
  input logic clk_i,
  input logic rst_ni,
  lobm_order_if.sink    order_i,
  lobm_result_if.source result_o
);
  logic   q_valid, q_pop;
  order_t q_word;

  lobm_front u_front (
    .clk_i, .rst_ni, .in_i(order_i),
    .q_valid_o(q_valid), .q_word_o(q_word), .q_pop_i(q_pop));

  lobm_engine #(.PriceLevels(PRICE_LEVELS), .QueueDepth(LEVEL_QUEUE_DEPTH)) u_engine (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_word_i(q_word),
    .q_pop_o(q_pop), .out_o(result_o));
endmodule
